FILE: design/ball_roll_acceleration_macros.svh
// Assertion helpers for the rolling ball acceleration block.
// Both forms use the clock clk and are disabled while rst is high.
`ifndef BALL_ROLL_ACCELERATION_MACROS_SVH
`define BALL_ROLL_ACCELERATION_MACROS_SVH

// Same-cycle implication.
`define BRA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ball roll acceleration check failed");

// Next-cycle implication.
`define BRA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ball roll acceleration check failed");

`endif

FILE: design/bra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_pkg
// Types, codes and helpers shared by the rolling ball acceleration block.
// ----------------------------------------------------------------------------
package bra_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_FRICTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLAT_COS = 2'd3;

  localparam logic [1:0] MODE_SLOW = 2'd0;
  localparam logic [1:0] MODE_FLAT = 2'd1;
  localparam logic [1:0] MODE_SLOPE = 2'd2;

  localparam int IN_DATA_W = 104;
  localparam int OUT_DATA_W = 80;

  typedef struct packed {
    logic sx;
    logic sy;
    logic [24:0] mx;
    logic [24:0] my;
    logic [25:0] fric;
    logic signed [28:0] tx;
    logic signed [28:0] ty;
    logic signed [28:0] tz;
    logic flat;
  } side_t;

  function automatic logic [24:0] sat25(input logic signed [29:0] v);
    logic [24:0] r;
    if (v > 30'sd16777215) begin
      r = 25'h0FFFFFF;
    end else if (v < -30'sd16777216) begin
      r = 25'h1000000;
    end else begin
      r = v[24:0];
    end
    return r;
  endfunction

endpackage

FILE: design/ball_roll_acceleration.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ball_roll_acceleration
// Pipelined acceleration of a rolling ball from its velocity and ground normal.
// ----------------------------------------------------------------------------
// The slave stream carries one ball per beat: velocity x and y and the ground
// normal. The master stream returns one beat per input beat with the
// saturated acceleration in tdata and the roll mode in tuser.
// The four registers are written through cfg_we, cfg_index and cfg_data.
// A new beat can be taken in every cycle while the pipeline is not frozen.
// The path runs through the square root, which resolves one root bit per
// stage over 25 stages, and the two direction dividers, which resolve one
// quotient bit per stage over 26 stages; stages A to C with their
// multipliers come before the square root, stage D between it and the
// dividers, and one output register after.
// When the receiver holds tready low while a beat waits, the whole pipeline
// freezes and s_tready falls; nothing is dropped or repeated.
// A synchronous reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module ball_roll_acceleration
  import bra_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // vel_x[24:0], vel_y[49:25], normal_x[65:50], normal_y[81:66], normal_z[97:82]
  input  logic [IN_DATA_W-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // accel_x[24:0], accel_y[49:25], accel_z[74:50]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // roll_mode[1:0]
  output logic [1:0] m_tuser,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [16:0] rolling_friction;
  logic [23:0] gravity_accel;
  logic [15:0] min_speed;
  logic [14:0] flat_cosine;

  always_ff @(posedge clk) begin
    if (rst) begin
      rolling_friction <= 17'd6554;
      gravity_accel <= 24'd2108555;
      min_speed <= 16'd655;
      flat_cosine <= 15'd16368;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRICTION: rolling_friction <= cfg_data[16:0];
        REG_GRAVITY: gravity_accel <= cfg_data;
        REG_MIN_SPEED: min_speed <= cfg_data[15:0];
        REG_FLAT_COS: flat_cosine <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  // Stage A: squares and the first products.
  logic signed [24:0] in_vx, in_vy;
  logic signed [15:0] in_nx, in_ny, in_nz;
  logic signed [49:0] px, py;
  logic signed [40:0] pg;
  logic [40:0] pmg;

  assign in_vx = $signed(s_tdata[24:0]);
  assign in_vy = $signed(s_tdata[49:25]);
  assign in_nx = $signed(s_tdata[65:50]);
  assign in_ny = $signed(s_tdata[81:66]);
  assign in_nz = $signed(s_tdata[97:82]);
  assign px = in_vx * in_vx;
  assign py = in_vy * in_vy;
  assign pg = $signed({1'b0, gravity_accel}) * in_nz;
  assign pmg = rolling_friction * gravity_accel;

  logic a_v;
  logic signed [24:0] a_vx, a_vy;
  logic signed [15:0] a_nx, a_ny, a_nz;
  logic [48:0] a_sqx, a_sqy;
  logic signed [40:0] a_gnz;
  logic [40:0] a_mug;

  always_ff @(posedge clk) begin
    if (en) begin
      a_vx <= in_vx;
      a_vy <= in_vy;
      a_nx <= in_nx;
      a_ny <= in_ny;
      a_nz <= in_nz;
      a_sqx <= px[48:0];
      a_sqy <= py[48:0];
      a_gnz <= pg;
      a_mug <= pmg;
    end
  end

  // Stage B: sum of squares, gravity tangent products, normal force.
  logic signed [56:0] ptx, pty, ptz;
  logic [40:0] gabs;

  assign ptx = a_gnz * a_nx;
  assign pty = a_gnz * a_ny;
  assign ptz = a_gnz * a_nz;
  assign gabs = a_gnz[40] ? 41'(-a_gnz) : 41'(a_gnz);

  logic b_v;
  logic signed [24:0] b_vx, b_vy;
  logic [49:0] b_sq;
  logic signed [56:0] b_txf, b_tyf, b_tzf;
  logic [25:0] b_nf;
  logic [24:0] b_decel;
  logic b_flat;

  always_ff @(posedge clk) begin
    if (en) begin
      b_vx <= a_vx;
      b_vy <= a_vy;
      b_sq <= {1'b0, a_sqx} + {1'b0, a_sqy};
      b_txf <= ptx;
      b_tyf <= pty;
      b_tzf <= ptz;
      b_nf <= gabs[39:14];
      b_decel <= a_mug[40:16];
      b_flat <= a_nz > $signed({1'b0, flat_cosine});
    end
  end

  // Stage C: friction magnitude and the terms of the result.
  logic [42:0] pfr;
  side_t c_side;

  assign pfr = b_nf * rolling_friction;

  always_comb begin
    c_side.sx = b_vx[24];
    c_side.sy = b_vy[24];
    c_side.mx = b_vx[24] ? 25'(-b_vx) : 25'(b_vx);
    c_side.my = b_vy[24] ? 25'(-b_vy) : 25'(b_vy);
    c_side.flat = b_flat;
    if (b_flat) begin
      c_side.fric = {1'b0, b_decel};
      c_side.tx = '0;
      c_side.ty = '0;
      c_side.tz = '0;
    end else begin
      c_side.fric = pfr[41:16];
      c_side.tx = b_txf[56:28];
      c_side.ty = b_tyf[56:28];
      c_side.tz = $signed(b_tzf[56:28]) - $signed({5'd0, gravity_accel});
    end
  end

  // Square root: one root bit per stage, remainder kept as x - root^2.
  logic rt_v [0:25];
  logic [49:0] rt_rem [0:25];
  logic [24:0] rt_root [0:25];
  side_t rt_side [0:25];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      rt_v[0] <= 1'b0;
    end else if (en) begin
      a_v <= s_tvalid;
      b_v <= a_v;
      rt_v[0] <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rt_rem[0] <= b_sq;
      rt_root[0] <= '0;
      rt_side[0] <= c_side;
    end
  end

  for (genvar k = 1; k <= 25; k++) begin : g_sqrt
    localparam int I = 25 - k;
    logic [50:0] trial;
    logic [50:0] diff;
    logic take;

    assign trial = ({26'd0, rt_root[k-1]} << (I + 1)) + (51'd1 << (2 * I));
    assign diff = {1'b0, rt_rem[k-1]} - trial;
    assign take = {1'b0, rt_rem[k-1]} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        rt_v[k] <= 1'b0;
      end else if (en) begin
        rt_v[k] <= rt_v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt_rem[k] <= take ? diff[49:0] : rt_rem[k-1];
        rt_root[k] <= take ? (rt_root[k-1] | (25'd1 << I)) : rt_root[k-1];
        rt_side[k] <= rt_side[k-1];
      end
    end
  end

  // Stage D: dividends for the direction terms and the speed test.
  logic [24:0] speed;
  logic [50:0] pnx, pny;
  logic slow;

  assign speed = rt_root[25];
  assign pnx = rt_side[25].fric * rt_side[25].mx;
  assign pny = rt_side[25].fric * rt_side[25].my;
  assign slow = (speed == '0) || (speed < {9'd0, min_speed});

  logic dv_v [0:26];
  logic [24:0] dv_rx [0:26];
  logic [24:0] dv_ry [0:26];
  logic [25:0] dv_nx [0:26];
  logic [25:0] dv_ny [0:26];
  logic [25:0] dv_qx [0:26];
  logic [25:0] dv_qy [0:26];
  logic [24:0] dv_speed [0:26];
  logic dv_slow [0:26];
  side_t dv_side [0:26];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= rt_v[25];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rx[0] <= {1'b0, pnx[49:26]};
      dv_ry[0] <= {1'b0, pny[49:26]};
      dv_nx[0] <= pnx[25:0];
      dv_ny[0] <= pny[25:0];
      dv_qx[0] <= '0;
      dv_qy[0] <= '0;
      dv_speed[0] <= speed;
      dv_slow[0] <= slow;
      dv_side[0] <= rt_side[25];
    end
  end

  // Restoring division: one quotient bit per stage for x and for y.
  for (genvar k = 1; k <= 26; k++) begin : g_div
    localparam int I = 26 - k;
    logic [25:0] tx_w, ty_w, dx_w, dy_w;
    logic gx, gy;

    assign tx_w = {dv_rx[k-1], dv_nx[k-1][I]};
    assign ty_w = {dv_ry[k-1], dv_ny[k-1][I]};
    assign gx = tx_w >= {1'b0, dv_speed[k-1]};
    assign gy = ty_w >= {1'b0, dv_speed[k-1]};
    assign dx_w = tx_w - {1'b0, dv_speed[k-1]};
    assign dy_w = ty_w - {1'b0, dv_speed[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k] <= 1'b0;
      end else if (en) begin
        dv_v[k] <= dv_v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rx[k] <= gx ? dx_w[24:0] : tx_w[24:0];
        dv_ry[k] <= gy ? dy_w[24:0] : ty_w[24:0];
        dv_nx[k] <= dv_nx[k-1];
        dv_ny[k] <= dv_ny[k-1];
        dv_qx[k] <= dv_qx[k-1] | (26'(gx) << I);
        dv_qy[k] <= dv_qy[k-1] | (26'(gy) << I);
        dv_speed[k] <= dv_speed[k-1];
        dv_slow[k] <= dv_slow[k-1];
        dv_side[k] <= dv_side[k-1];
      end
    end
  end

  // Output stage: signs, final sums and saturation.
  side_t fs;
  logic signed [26:0] qx_s, qy_s;
  logic signed [29:0] ax_w, ay_w;
  logic [24:0] ax, ay, az;
  logic [1:0] mode;

  assign fs = dv_side[26];
  assign qx_s = fs.sx ? -$signed({1'b0, dv_qx[26]}) : $signed({1'b0, dv_qx[26]});
  assign qy_s = fs.sy ? -$signed({1'b0, dv_qy[26]}) : $signed({1'b0, dv_qy[26]});
  assign ax_w = 30'(fs.tx) - 30'(qx_s);
  assign ay_w = 30'(fs.ty) - 30'(qy_s);

  always_comb begin
    if (dv_slow[26]) begin
      ax = '0;
      ay = '0;
      az = '0;
      mode = MODE_SLOW;
    end else begin
      ax = sat25(ax_w);
      ay = sat25(ay_w);
      az = sat25(30'(fs.tz));
      mode = fs.flat ? MODE_FLAT : MODE_SLOPE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_v[26];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {5'd0, az, ay, ax};
      m_tuser <= mode;
    end
  end

endmodule

FILE: design/bra_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_checker
// Port-level checks on the rolling ball acceleration block, bound to the top.
// ----------------------------------------------------------------------------
`include "ball_roll_acceleration_macros.svh"

module bra_checker
  import bra_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [1:0] m_tuser
);

  `BRA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  `BRA_ASSERT_NOW(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready)
  `BRA_ASSERT_NOW(a_slow_is_zero, m_tvalid && m_tuser == MODE_SLOW, m_tdata == '0)
  `BRA_ASSERT_NOW(a_flat_no_z, m_tvalid && m_tuser == MODE_FLAT, m_tdata[74:50] == '0)
  `BRA_ASSERT_NOW(a_mode_code, m_tvalid, m_tuser == MODE_SLOW || m_tuser == MODE_FLAT || m_tuser == MODE_SLOPE)

endmodule

bind ball_roll_acceleration bra_checker u_bra_checker (
  .clk(clk),
  .rst(rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata),
  .m_tuser(m_tuser)
);
